[src/adc_conversion_register_interface_assert.svh]
// ---------------------------------------------------------------------------
// ADC register interface assertion macros
// Concurrent check macros shared by the block's modules; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ADC_CONVERSION_REGISTER_INTERFACE_ASSERT_SVH
`define ADC_CONVERSION_REGISTER_INTERFACE_ASSERT_SVH
`ifndef SYNTHESIS
// ante holds -> cons holds in the same cycle
`define ACRI_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
// ante holds -> cons holds in the next cycle
`define ACRI_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define ACRI_ASSERT_SAME(lbl, ck, rs, ante, cons, msg)
`define ACRI_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

[src/acri_pkg.sv]
// ---------------------------------------------------------------------------
// ADC register interface package
// Command codes, register indexes, reset values and the queued word types.
// ---------------------------------------------------------------------------
package acri_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  localparam logic [1:0] REG_STATUS = 2'd0;
  localparam logic [1:0] REG_HIGH   = 2'd1;
  localparam logic [1:0] REG_LOW    = 2'd2;

  localparam logic CFG_SHORT_TICKS = 1'b0;
  localparam logic CFG_LONG_TICKS  = 1'b1;

  localparam logic [15:0] SHORT_TICKS_RST = 16'd8000;
  localparam logic [15:0] LONG_TICKS_RST  = 16'd20000;
  localparam logic [15:0] CHAN_VALUE_RST  = 16'h8000;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_READ,
    OP_CTRL,
    OP_SET,
    OP_TICK
  } op_t;

  // classified input word: val carries sample_value or time_delta
  typedef struct packed {
    op_t         op;
    logic [1:0]  addr;
    logic [3:0]  ctrl;
    logic [1:0]  chan;
    logic [15:0] val;
  } item_t;

  // front to back queue head
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       eoc;
  } res_t;

endpackage

[src/acri_front.sv]
// ---------------------------------------------------------------------------
// ADC register interface front end
// Accepts input words, classifies the command and queues it for the back end.
// ---------------------------------------------------------------------------
`include "adc_conversion_register_interface_assert.svh"
module acri_front
  import acri_pkg::*;
#(
  parameter int NUM_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [1:0]  reg_addr,
  input  logic [7:0]  write_data,
  input  logic [1:0]  sample_channel,
  input  logic [15:0] sample_value,
  input  logic [15:0] time_delta,
  output head_t       head,
  input  logic        take
);

  item_t      dec;
  item_t      q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_take;

  always_comb begin
    dec.addr = reg_addr;
    dec.ctrl = write_data[3:0];
    dec.chan = sample_channel;
    dec.val  = (command == CMD_SET) ? sample_value : time_delta;
    unique case (command)
      CMD_READ:  dec.op = OP_READ;
      CMD_WRITE: dec.op = (reg_addr == REG_STATUS) ? OP_CTRL : OP_NOP;
      CMD_SET:   dec.op = ({1'b0, sample_channel} < 3'(NUM_CHANNELS)) ? OP_SET : OP_NOP;
      default:   dec.op = OP_TICK;
    endcase
  end

  assign full       = (count == 2'd2);
  assign do_push    = push && !full;
  assign do_take    = take && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.item  = q[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_take) rptr <= ~rptr;
      count <= count + {1'b0, do_push} - {1'b0, do_take};
    end
  end

  `ACRI_ASSERT_SAME(a_count_range, clk, rst, 1'b1, count != 2'd3, "front queue overrun")
  `ACRI_ASSERT_NEXT(a_push_grows, clk, rst, do_push && !do_take, count == $past(count) + 2'd1, "front count missed a push")
  `ACRI_ASSERT_NEXT(a_take_shrinks, clk, rst, do_take && !do_push, count == $past(count) - 2'd1, "front count missed a take")

endmodule

[src/acri_back.sv]
// ---------------------------------------------------------------------------
// ADC register interface back end
// Executes queued words against the converter state and queues the results.
// ---------------------------------------------------------------------------
`include "adc_conversion_register_interface_assert.svh"
module acri_back
  import acri_pkg::*;
#(
  parameter int NUM_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  head_t       head,
  output logic        take,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  read_data,
  output logic        eoc_line
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [15:0] short_ticks;
  logic [15:0] long_ticks;
  logic [15:0] chan_vals [NUM_CHANNELS];
  logic [1:0]  sel;
  logic        flag;
  logic        long_mode;
  logic        busy;
  logic        result_ready;
  logic [15:0] remaining;

  logic [1:0]  sel_next;
  logic        flag_next;
  logic        long_mode_next;
  logic        busy_next;
  logic        result_ready_next;
  logic [15:0] remaining_next;

  logic [15:0] cur_val;
  logic [7:0]  rd;
  logic        step;
  item_t       it;

  res_t        oq [2];
  logic        owptr;
  logic        orptr;
  logic [1:0]  ocount;
  logic        do_pop;

  assign it     = head.item;
  assign step   = head.valid && (ocount != 2'd2);
  assign take   = step;
  assign do_pop = pop && (ocount != 2'd0);
  assign empty  = (ocount == 2'd0);
  assign read_data = oq[orptr].read_data;
  assign eoc_line  = oq[orptr].eoc;

  // out-of-range selection reads as zero
  assign cur_val = ({1'b0, sel} < 3'(NUM_CHANNELS)) ? chan_vals[sel[CH_W-1:0]] : 16'd0;

  always_comb begin
    sel_next          = sel;
    flag_next         = flag;
    long_mode_next    = long_mode;
    busy_next         = busy;
    result_ready_next = result_ready;
    remaining_next    = remaining;
    rd                = 8'd0;
    unique case (it.op)
      OP_READ: begin
        case (it.addr)
          REG_STATUS: rd = {~result_ready, ~busy, cur_val[15], cur_val[14],
                            long_mode, flag, sel};
          REG_HIGH:   rd = cur_val[15:8];
          REG_LOW:    rd = {cur_val[7:4], 4'd0};
          default:    rd = 8'd0;
        endcase
      end
      OP_CTRL: begin
        sel_next          = it.ctrl[1:0];
        flag_next         = it.ctrl[2];
        long_mode_next    = it.ctrl[3];
        remaining_next    = it.ctrl[3] ? long_ticks : short_ticks;
        busy_next         = 1'b1;
        result_ready_next = 1'b0;
      end
      OP_TICK: begin
        if (busy) begin
          if (it.val >= remaining) begin
            remaining_next    = 16'd0;
            busy_next         = 1'b0;
            result_ready_next = 1'b1;
          end else begin
            remaining_next = remaining - it.val;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks <= SHORT_TICKS_RST;
      long_ticks  <= LONG_TICKS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SHORT_TICKS: short_ticks <= cfg_wdata;
        default:         long_ticks  <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) chan_vals[i] <= CHAN_VALUE_RST;
    end else if (step && it.op == OP_SET) begin
      chan_vals[it.chan[CH_W-1:0]] <= it.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel          <= 2'd0;
      flag         <= 1'b0;
      long_mode    <= 1'b0;
      busy         <= 1'b0;
      result_ready <= 1'b0;
      remaining    <= 16'd0;
    end else if (step) begin
      sel          <= sel_next;
      flag         <= flag_next;
      long_mode    <= long_mode_next;
      busy         <= busy_next;
      result_ready <= result_ready_next;
      remaining    <= remaining_next;
    end
  end

  // result queue; eoc follows busy after the word
  always_ff @(posedge clk) begin
    if (step) begin
      oq[owptr] <= '{read_data: rd, eoc: busy_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr  <= 1'b0;
      orptr  <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (step)   owptr <= ~owptr;
      if (do_pop) orptr <= ~orptr;
      ocount <= ocount + {1'b0, step} - {1'b0, do_pop};
    end
  end

  `ACRI_ASSERT_SAME(a_ocount_range, clk, rst, 1'b1, ocount != 2'd3, "result queue overrun")
  `ACRI_ASSERT_SAME(a_busy_fall, clk, rst, !$past(rst) && $fell(busy), $past(step) && ($past(it.op) == OP_TICK), "busy dropped without a tick")
  `ACRI_ASSERT_SAME(a_busy_rise, clk, rst, !$past(rst) && $rose(busy), $past(step) && ($past(it.op) == OP_CTRL), "busy raised without a control write")

endmodule

[src/adc_conversion_register_interface.sv]
// ---------------------------------------------------------------------------
// ADC register interface
// Four-channel converter register file with a tick-driven conversion timer.
// ---------------------------------------------------------------------------
//   channel  | direction | handshake        | payload
//   input    | in        | push / full      | command, reg_addr, write_data,
//            |           |                  | sample_channel, sample_value, time_delta
//   result   | out       | empty / pop      | read_data, eoc_line
//   config   | in        | cfg_write        | cfg_index, cfg_wdata
//
// One word per cycle sustained while results are popped; a result reaches the result
// ports through the front queue, then the back-end result queue.
// rst is synchronous: both queues empty, state and tick counts at defaults.
// Each side stalls on its own: a full result queue holds the back end, and
// the front queue keeps accepting until both its entries are filled.
// ---------------------------------------------------------------------------
module adc_conversion_register_interface
  import acri_pkg::*;
#(
  parameter int NUM_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [1:0]  reg_addr,
  input  logic [7:0]  write_data,
  input  logic [1:0]  sample_channel,
  input  logic [15:0] sample_value,
  input  logic [15:0] time_delta,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  read_data,
  output logic        eoc_line,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  head_t head;
  logic  take;

  acri_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .command        (command),
    .reg_addr       (reg_addr),
    .write_data     (write_data),
    .sample_channel (sample_channel),
    .sample_value   (sample_value),
    .time_delta     (time_delta),
    .head           (head),
    .take           (take)
  );

  acri_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .take      (take),
    .empty     (empty),
    .pop       (pop),
    .read_data (read_data),
    .eoc_line  (eoc_line)
  );

endmodule
